// ----- hw/rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// shared types and constants for the chunked byte ring buffer
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEF    = 4096;
  localparam int MAX_READ_DEF = 64;
  localparam int SIZE_RESET   = 4096;

  localparam int SIZE_W = 13;
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 12;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [LEN_W-1:0]   length;
    logic [BYTE_W-1:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [BYTE_W-1:0]  read_byte;
    logic               last;
    logic [FILL_W-1:0]  fill_level;
  } res_t;

endpackage

// ----- hw/rtl/brb_store.sv -----
// ----------------------------------------------------------------------------
// brb_store
// byte store of the ring, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module brb_store #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [brb_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [brb_pkg::BYTE_W-1:0] q
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl
// pointer, fill and chunk bookkeeping; sequences reads through the store
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_READ = brb_pkg::MAX_READ_DEF,
  parameter int AW       = $clog2(DEPTH),
  parameter int SW       = AW + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [SW-1:0]              ring,
  input  logic                       start,
  input  brb_pkg::cmd_t              cmd,
  output logic                       busy,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [brb_pkg::BYTE_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [brb_pkg::BYTE_W-1:0] mem_q,
  output logic                       result_valid,
  output brb_pkg::res_t              result
);

  localparam int LW = brb_pkg::LEN_W;
  localparam int CW = ((AW > LW) ? AW : LW) + 2;
  localparam int RW = $clog2(MAX_READ + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] used, used_next;
  logic [LW-1:0] chunk_left, chunk_left_next;
  logic          chunk_acc, chunk_acc_next;
  logic [RW-1:0] rd_left, rd_left_next;
  logic          res_valid, res_valid_next;
  brb_pkg::res_t res, res_next;

  logic [AW-1:0] head_inc, tail_inc;
  logic [CW-1:0] head_sum;
  logic [RW-1:0] rd_count;
  logic          fits, room, acc, wr_status;

  assign busy         = (state == ST_READ);
  assign result_valid = res_valid;
  assign result       = res;

  always_comb begin
    head_inc = (SW'(head) + 1'b1 == ring) ? '0 : head + 1'b1;
    tail_inc = (SW'(tail) + 1'b1 == ring) ? '0 : tail + 1'b1;
    head_sum = CW'(head) + CW'(cmd.length);
    if (head_sum >= CW'(ring)) begin
      head_sum = head_sum - CW'(ring);
    end
    rd_count = (cmd.length > LW'(MAX_READ)) ? RW'(MAX_READ) : RW'(cmd.length);
    fits = (CW'(cmd.length) + CW'(used) + 1'b1) <= CW'(ring);
    room = (CW'(used) + 1'b1) < CW'(ring);
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    used_next       = used;
    chunk_left_next = chunk_left;
    chunk_acc_next  = chunk_acc;
    rd_left_next    = rd_left;
    res_valid_next  = 1'b0;
    res_next        = res;
    mem_we          = 1'b0;
    mem_waddr       = tail;
    mem_wdata       = cmd.data_byte;
    mem_re          = 1'b0;
    mem_raddr       = head;
    acc             = chunk_acc;
    wr_status       = 1'b0;

    if (clear) begin
      head_next       = '0;
      tail_next       = '0;
      used_next       = '0;
      chunk_left_next = '0;
      chunk_acc_next  = 1'b0;
      state_next      = ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (cmd.operation)
              brb_pkg::OP_WRITE: begin
                res_valid_next = 1'b1;
                if (chunk_left == '0 && cmd.length == '0) begin
                  // empty chunk: nothing stored, nothing left open
                  chunk_acc_next = 1'b0;
                end else begin
                  if (chunk_left == '0) begin
                    acc             = fits;
                    chunk_left_next = cmd.length - 1'b1;
                  end else begin
                    chunk_left_next = chunk_left - 1'b1;
                  end
                  chunk_acc_next = acc;
                  wr_status      = !acc;
                  if (acc) begin
                    if (room) begin
                      mem_we    = 1'b1;
                      tail_next = tail_inc;
                      used_next = used + 1'b1;
                    end else begin
                      wr_status = 1'b1;
                    end
                  end
                end
                res_next = '{status: wr_status, read_byte: '0, last: 1'b1,
                             fill_level: brb_pkg::FILL_W'(used_next)};
              end
              brb_pkg::OP_READ: begin
                res_next = '{status: 1'b0, read_byte: '0, last: 1'b1,
                             fill_level: brb_pkg::FILL_W'(used)};
                if (CW'(rd_count) > CW'(used)) begin
                  res_valid_next  = 1'b1;
                  res_next.status = 1'b1;
                end else if (rd_count == '0) begin
                  res_valid_next = 1'b1;
                end else begin
                  // first byte fetched now; the store registers it, then the result register shows it
                  mem_re       = 1'b1;
                  head_next    = head_inc;
                  rd_left_next = rd_count - 1'b1;
                  state_next   = ST_READ;
                end
              end
              brb_pkg::OP_DISCARD: begin
                res_valid_next = 1'b1;
                if (CW'(cmd.length) > CW'(used)) begin
                  res_next = '{status: 1'b1, read_byte: '0, last: 1'b1,
                               fill_level: brb_pkg::FILL_W'(used)};
                end else begin
                  head_next = AW'(head_sum);
                  used_next = used - AW'(cmd.length);
                  res_next  = '{status: 1'b0, read_byte: '0, last: 1'b1,
                                fill_level: brb_pkg::FILL_W'(used_next)};
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          res_valid_next = 1'b1;
          used_next      = used - 1'b1;
          res_next       = '{status: 1'b0, read_byte: mem_q, last: (rd_left == '0),
                             fill_level: brb_pkg::FILL_W'(used_next)};
          if (rd_left != '0) begin
            mem_re       = 1'b1;
            head_next    = head_inc;
            rd_left_next = rd_left - 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      used       <= '0;
      chunk_left <= '0;
      chunk_acc  <= 1'b0;
      rd_left    <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      used       <= used_next;
      chunk_left <= chunk_left_next;
      chunk_acc  <= chunk_acc_next;
      rd_left    <= rd_left_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ----- hw/rtl/byte_ring_buffer_chunked.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked
// circular byte fifo with all-or-nothing chunk writes, counted reads, discards
// ----------------------------------------------------------------------------
// results: write and discard words, and rejected or empty reads, give their
//   result from the result register in the cycle after start is taken; a read
//   of n bytes gives its bytes through the store's read register and then the
//   result register, one byte per cycle; one write or discard per cycle while
//   busy is low; a read holds busy while its bytes pass the single read port
// reset: pointers, fill and chunk state cleared, ring size 4096 capped at
//   DEPTH, store contents undefined; results cannot be stalled by the receiver
module byte_ring_buffer_chunked #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_READ = brb_pkg::MAX_READ_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // command word in
  input  logic                       start,
  output logic                       busy,
  input  brb_pkg::cmd_t              cmd,
  // result word out, one-cycle strobe
  output logic                       result_valid,
  output brb_pkg::res_t              result,
  // ring size register
  input  logic                       cfg_we,
  input  logic [brb_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  // ring size needs one more bit than an index, it can equal DEPTH
  localparam int SW = AW + 1;
  localparam int KW = (SW > brb_pkg::SIZE_W) ? SW : brb_pkg::SIZE_W;
  localparam int RESET_RING = (brb_pkg::SIZE_RESET > DEPTH) ? DEPTH : brb_pkg::SIZE_RESET;

  logic [SW-1:0]              ring, ring_next;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [brb_pkg::BYTE_W-1:0] mem_wdata, mem_q;

  // clamp the written size into 2..DEPTH once, at write time
  always_comb begin
    if (KW'(cfg_wdata) < KW'(2)) begin
      ring_next = SW'(2);
    end else if (KW'(cfg_wdata) > KW'(DEPTH)) begin
      ring_next = SW'(DEPTH);
    end else begin
      ring_next = SW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= SW'(RESET_RING);
    end else if (cfg_we) begin
      ring <= ring_next;
    end
  end

  // pointer and fill bookkeeping, read sequencing; a size write empties the ring
  brb_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ),
    .AW       (AW),
    .SW       (SW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_we),
    .ring         (ring),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_q        (mem_q),
    .result_valid (result_valid),
    .result       (result)
  );

  // byte store; reads and writes never fall in the same cycle, so no bypass
  brb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .q     (mem_q)
  );

endmodule

// ----- verif/tb_byte_ring_buffer_chunked.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_chunked
// checks the chunked byte ring buffer against its own software picture of the
// ring: directed corner words first, then random chunk, read and discard
// traffic over several ring sizes, every result word compared field by field
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_chunked;
  import brb_pkg::*;

  // operation code the block ignores, not part of op_t
  localparam logic [1:0] OP_IGNORED   = 2'd3;
  // idle cycles after the last expected result before a register write or end
  localparam int         DRAIN_CYCLES = 8;
  // whole-run cycle budget, far above the slowest legal run
  localparam int         CYCLE_LIMIT  = 200000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  cmd_t              cmd       = '0;
  logic              result_valid;
  res_t              result;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // software copy of the ring
  logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
  int                rd_ptr;
  int                wr_ptr;
  int                chunk_left;
  bit                chunk_ok;
  logic [SIZE_W-1:0] ring_size_reg;

  // result words still owed by the block, oldest first
  res_t pending_results [$];
  res_t want;
  int   error_count = 0;
  int   word_count  = 0;
  // set for stretches of back-to-back words
  bit   steady      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_ring_buffer_chunked dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // ring picture
  // ---------------------------------------------------------------------------

  // ring size in use, register value clamped to 2..DEPTH
  function automatic int ring_slots();
    int s;
    s = ring_size_reg;
    if (s < 2) s = 2;
    if (s > DEPTH_DEF) s = DEPTH_DEF;
    return s;
  endfunction

  // bytes held, pointers always stay below the ring size
  function automatic int ring_held();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + ring_slots() - rd_ptr;
  endfunction

  // fill level is taken after the state change that the result reports
  function automatic void expect_result(logic st, logic [BYTE_W-1:0] rb, logic lst);
    res_t r;
    r.status     = st;
    r.read_byte  = rb;
    r.last       = lst;
    r.fill_level = FILL_W'(ring_held());
    pending_results.push_back(r);
  endfunction

  // advance the ring picture by one accepted command word
  function automatic void ring_apply_word(cmd_t c);
    int   s;
    int   used;
    int   n;
    int   i;
    logic st;
    s    = ring_slots();
    used = ring_held();
    case (c.operation)
      OP_WRITE: begin
        if (chunk_left == 0 && c.length == 0) begin
          // empty chunk: accepted, nothing stored, nothing left open
          chunk_ok = 1'b0;
          expect_result(1'b0, '0, 1'b1);
        end else begin
          // first byte of a chunk decides for the whole chunk
          if (chunk_left == 0) begin
            chunk_ok   = (c.length + used + 1 <= s);
            chunk_left = c.length - 1;
          end else begin
            chunk_left--;
          end
          st = !chunk_ok;
          if (chunk_ok) begin
            if (used + 1 < s) begin
              ring_mem[wr_ptr] = c.data_byte;
              wr_ptr = (wr_ptr + 1) % s;
            end else begin
              // no free slot after all: byte dropped
              st = 1'b1;
            end
          end
          expect_result(st, '0, 1'b1);
        end
      end
      OP_READ: begin
        n = (c.length > MAX_READ_DEF) ? MAX_READ_DEF : int'(c.length);
        if (n > used) begin
          expect_result(1'b1, '0, 1'b1);
        end else if (n == 0) begin
          expect_result(1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            rd_ptr = (rd_ptr + 1) % s;
            expect_result(1'b0, ring_mem[(rd_ptr + s - 1) % s], (i == n - 1));
          end
        end
      end
      OP_DISCARD: begin
        if (c.length > used) begin
          expect_result(1'b1, '0, 1'b1);
        end else begin
          rd_ptr = (rd_ptr + c.length) % s;
          expect_result(1'b0, '0, 1'b1);
        end
      end
      default: begin
        // ignored code, no result
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker, the receiver can never stall so every strobe is taken
  // fields shown as status/byte/last/fill
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: expected no word, got %0d/%02h/%0d/%0d",
                 $time, result.status, result.read_byte, result.last, result.fill_level);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.read_byte !== want.read_byte ||
            result.last !== want.last || result.fill_level !== want.fill_level) begin
          error_count++;
          $display("%0t: expected %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
                   $time, want.status, want.read_byte, want.last, want.fill_level,
                   result.status, result.read_byte, result.last, result.fill_level);
        end
      end
    end
  end

  // run watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_byte_ring_buffer_chunked: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus plumbing
  // ---------------------------------------------------------------------------

  // mostly short gaps, some long ones, none during steady stretches
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one command word and hold it until the block takes it
  task automatic send_word(input logic [1:0] op, input int len, input int dat);
    cmd_t c;
    int   gap;
    c.operation = op_t'(op);
    c.length    = LEN_W'(len);
    c.data_byte = BYTE_W'(dat);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    ring_apply_word(c);
    if (op != OP_IGNORED) word_count++;
    // with no gap start stays high for the next word
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // all owed results in, then the drain wait for ignored words still in flight
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // size write empties the ring and closes any open chunk
  task automatic set_ring_size(input int sz);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(sz);
    @(posedge clk);
    ring_size_reg = SIZE_W'(sz);
    rd_ptr        = 0;
    wr_ptr        = 0;
    chunk_left    = 0;
    chunk_ok      = 1'b0;
    cfg_we       <= 1'b0;
  endtask

  // read count: mostly legal, some too long, zero, or above the read cap
  task automatic random_read();
    int used;
    int cap;
    int n;
    int r;
    used = ring_held();
    cap  = (used < MAX_READ_DEF) ? used : MAX_READ_DEF;
    r    = $urandom_range(0, 99);
    if (r < 60) n = (cap == 0) ? 0 : $urandom_range(1, cap);
    else if (r < 75) n = used + $urandom_range(1, 8);
    else if (r < 85) n = 0;
    else n = $urandom_range(MAX_READ_DEF + 1, 4095);
    if (n > 4095) n = 4095;
    send_word(OP_READ, n, $urandom_range(0, 255));
  endtask

  task automatic random_discard();
    int used;
    int n;
    used = ring_held();
    if ($urandom_range(0, 99) < 70) n = $urandom_range(0, used);
    else n = used + $urandom_range(1, 5);
    if (n > 4095) n = 4095;
    send_word(OP_DISCARD, n, $urandom_range(0, 255));
  endtask

  // one chunk, whole or cut short, with reads and discards slipped in between
  task automatic random_chunk(input bit cut_short, input int max_len);
    int s;
    int used;
    int room;
    int len;
    int count;
    int k;
    // a chunk left open earlier swallows the next write words, finish it
    if (chunk_left > 0) begin
      count = chunk_left;
      for (k = 0; k < count; k++)
        send_word(OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 255));
      return;
    end
    s    = ring_slots();
    used = ring_held();
    room = s - 1 - used;
    if ((room == 0 || $urandom_range(0, 6) == 0) && s - used <= 24)
      len = s - used + $urandom_range(0, 2);     // one to three bytes too many, rejected
    else if ($urandom_range(0, 19) == 0)
      len = 0;
    else
      len = $urandom_range(1, (room < max_len) ? room : max_len);
    count = (len == 0) ? 1 : (cut_short ? $urandom_range(1, len) : len);
    for (k = 0; k < count; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) random_read();
        else random_discard();
      end
      // length only counts on the first word, later ones carry noise
      send_word(OP_WRITE, (k == 0) ? len : $urandom_range(0, 4095), $urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size: empty-ring corners, extremes of every field, capped read
  task automatic test_default_size();
    send_word(OP_WRITE, 0, 8'hFF);      // empty chunk
    send_word(OP_READ, 0, 8'h00);       // read of nothing
    send_word(OP_READ, 1, 8'h00);       // read from an empty ring
    send_word(OP_DISCARD, 0, 8'h00);
    send_word(OP_DISCARD, 4095, 8'hFF); // more than held
    send_word(OP_IGNORED, 4095, 8'hFF);
    send_word(OP_WRITE, 3, 8'h00);
    send_word(OP_WRITE, 0, 8'hFF);
    send_word(OP_WRITE, 4095, 8'h5A);
    send_word(OP_READ, 4095, 8'h00);    // capped to max read, still too long
    send_word(OP_READ, 2, 8'hFF);
    send_word(OP_DISCARD, 1, 8'h00);
  endtask

  // clamped sizes, rejection, partial chunk visibility
  task automatic test_tiny_rings();
    set_ring_size(0);                   // used as two slots
    send_word(OP_WRITE, 1, 8'h3C);
    send_word(OP_WRITE, 1, 8'hC3);      // ring full, rejected
    send_word(OP_READ, 1, 8'h00);
    set_ring_size(1);
    send_word(OP_WRITE, 2, 8'h11);      // chunk too big, rejected
    send_word(OP_WRITE, 0, 8'h22);      // rest of that chunk, still rejected
    set_ring_size(5);
    send_word(OP_WRITE, 3, 8'h11);
    send_word(OP_READ, 1, 8'h00);       // sees the first byte of an open chunk
    send_word(OP_WRITE, 0, 8'h22);
    send_word(OP_DISCARD, 1, 8'h00);
    send_word(OP_WRITE, 0, 8'h33);
    send_word(OP_READ, 1, 8'h00);
    send_word(OP_WRITE, 4095, 8'h44);   // rejected, left open for the size write
  endtask

  task automatic test_random_traffic(input int sz, input int words, input int max_len,
                                     input int read_pct);
    int goal;
    int r;
    set_ring_size(sz);
    goal = word_count + words;
    while (word_count < goal) begin
      if ($urandom_range(0, 4) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < read_pct) random_read();
      else if (r < read_pct + 15) random_discard();
      else if (r < read_pct + 21)
        send_word(OP_IGNORED, $urandom_range(0, 4095), $urandom_range(0, 255));
      else if (r < read_pct + 27) random_chunk(1'b1, max_len);
      else random_chunk(1'b0, max_len);
    end
    steady = 1'b0;
  endtask

  initial begin
    ring_size_reg = SIZE_W'(SIZE_RESET);
    rd_ptr        = 0;
    wr_ptr        = 0;
    chunk_left    = 0;
    chunk_ok      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_default_size();
    test_tiny_rings();
    // size above the store depth, then the smallest and some odd sizes
    test_random_traffic(8191, 35, 12, 22);
    test_random_traffic(2, 25, 12, 22);
    test_random_traffic(7, 35, 12, 22);
    // write-heavy phases so the ring fills and reads hit the cap
    test_random_traffic(100, 40, 30, 10);
    test_random_traffic(4096, 60, 40, 8);
    test_random_traffic(3, 20, 12, 22);
    test_random_traffic(64, 30, 12, 22);

    wait_idle();
    if (error_count == 0) begin
      $display("tb_byte_ring_buffer_chunked: clean");
    end else begin
      $display("tb_byte_ring_buffer_chunked: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/brb_pkg.sv
hw/rtl/brb_store.sv
hw/rtl/brb_ctrl.sv
hw/rtl/byte_ring_buffer_chunked.sv
verif/tb_byte_ring_buffer_chunked.sv
